[design/csp_pkg.sv]
package csp_pkg;

    localparam int CRD_W          = 24;
    localparam int TEN_W          = 18;
    localparam int TIME_W         = 17;
    localparam int FRAC_W         = 16;
    localparam int NUMP_W         = 5;
    localparam int PIDX_W         = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int DEF_MAX_POINTS = 16;
    localparam int NSTG           = 10;

    localparam int U_W    = FRAC_W + 1;
    localparam int T2_W   = 2 * FRAC_W + 1;
    localparam int T3_W   = 3 * FRAC_W + 1;
    localparam int Q_W    = 3 * FRAC_W + 4;
    localparam int R_W    = 2 * FRAC_W;
    localparam int G_W    = 2 * FRAC_W + 2;
    localparam int S_W    = TEN_W + 1;
    localparam int SP_W   = S_W + R_W;
    localparam int W_W    = 2 * FRAC_W + 3;
    localparam int CP_W   = CRD_W + W_W;
    localparam int ACC_W  = CP_W + 2;
    localparam int RND_SH = 2 * FRAC_W;
    localparam int SUM_W  = ACC_W - RND_SH + 1;

    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    localparam logic signed [TEN_W-1:0] TENSION_RST = TEN_W'(32768);
    localparam logic [NUMP_W-1:0]       NUMP_RST    = NUMP_W'(2);

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TENSION    = 3'd0,
        CFG_NUM_POINTS = 3'd1,
        CFG_RELATIVE   = 3'd2,
        CFG_START_X    = 3'd3,
        CFG_START_Y    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [TEN_W-1:0] tension;
        logic [NUMP_W-1:0]       num_points;
        logic                    relative_mode;
        logic signed [CRD_W-1:0] start_x;
        logic signed [CRD_W-1:0] start_y;
    } t_cfg;

endpackage

[design/csp_if.sv]
interface csp_req_if;
    import csp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [PIDX_W-1:0]       point_index;
    logic signed [CRD_W-1:0] point_x;
    logic signed [CRD_W-1:0] point_y;
    logic [TIME_W-1:0]       sample_time;

    modport source (
        output valid, cmd, point_index, point_x, point_y, sample_time,
        input  ready
    );
    modport sink (
        input  valid, cmd, point_index, point_x, point_y, sample_time,
        output ready
    );
endinterface

interface csp_res_if;
    import csp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;

    modport source (output valid, pos_x, pos_y, input ready);
    modport sink (input valid, pos_x, pos_y, output ready);
endinterface

interface csp_cfg_if;
    import csp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/cardinal_spline_path_sampler.sv]
// Channel  Dir  Handshake     Carries
// i_req    in   valid/ready   cmd, point_index, point_x, point_y, sample_time
// o_res    out  valid/ready   pos_x, pos_y (one per sample request)
// i_cfg    in   valid/ready   index, data (ready always high)
//
// Ten register stages; one request per cycle while o_res.ready does not
// stall the pipeline. The stages cover index scaling, point table read,
// basis multiplies and blend.
// Load requests write the point table in stage three and produce no result.
// Reset sets the configuration registers; the point table is not cleared.
// A stage holds only when it and all later stages are full, so bubbles close.
module cardinal_spline_path_sampler #(
    parameter int MAX_POINTS = csp_pkg::DEF_MAX_POINTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csp_req_if.sink    i_req,
    csp_res_if.source  o_res,
    csp_cfg_if.sink    i_cfg
);
    import csp_pkg::*;

    localparam int PW = $clog2(MAX_POINTS);

    t_cfg            r_cfg;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] en;

    logic                    s1_load;
    logic [PIDX_W-1:0]       s1_idx;
    logic signed [CRD_W-1:0] s1_x;
    logic signed [CRD_W-1:0] s1_y;
    logic [U_W-1:0]          s1_u;
    logic [3:0][PW-1:0]      s1_addr;
    logic signed [CRD_W-1:0] s2_px [4];
    logic signed [CRD_W-1:0] s2_py [4];
    logic signed [W_W-1:0]   s6_w [4];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tension       <= TENSION_RST;
            r_cfg.num_points    <= NUMP_RST;
            r_cfg.relative_mode <= 1'b0;
            r_cfg.start_x       <= '0;
            r_cfg.start_y       <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_TENSION:    r_cfg.tension       <= i_cfg.data[TEN_W-1:0];
                CFG_NUM_POINTS: r_cfg.num_points    <= i_cfg.data[NUMP_W-1:0];
                CFG_RELATIVE:   r_cfg.relative_mode <= i_cfg.data[0];
                CFG_START_X:    r_cfg.start_x       <= i_cfg.data[CRD_W-1:0];
                CFG_START_Y:    r_cfg.start_y       <= i_cfg.data[CRD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld    = {r_vld[NSTG-2:0], i_req.valid};
        n_vld[2] = r_vld[1] && !s1_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign i_req.ready = en[0];
    assign o_res.valid = r_vld[NSTG-1];

    csp_front #(
        .MAX_POINTS (MAX_POINTS),
        .PW         (PW)
    ) u_front (
        .i_clk   (i_clk),
        .i_en    (en[1:0]),
        .i_cfg   (r_cfg),
        .i_cmd   (i_req.cmd),
        .i_idx   (i_req.point_index),
        .i_x     (i_req.point_x),
        .i_y     (i_req.point_y),
        .i_time  (i_req.sample_time),
        .o_load  (s1_load),
        .o_idx   (s1_idx),
        .o_x     (s1_x),
        .o_y     (s1_y),
        .o_u     (s1_u),
        .o_addr  (s1_addr)
    );

    csp_store #(
        .MAX_POINTS (MAX_POINTS),
        .PW         (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (en[2]),
        .i_vld   (r_vld[1]),
        .i_load  (s1_load),
        .i_idx   (s1_idx),
        .i_x     (s1_x),
        .i_y     (s1_y),
        .i_addr  (s1_addr),
        .o_px    (s2_px),
        .o_py    (s2_py)
    );

    csp_basis u_basis (
        .i_clk   (i_clk),
        .i_en    (en[6:2]),
        .i_cfg   (r_cfg),
        .i_u     (s1_u),
        .o_w     (s6_w)
    );

    csp_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (en[9:3]),
        .i_cfg   (r_cfg),
        .i_px    (s2_px),
        .i_py    (s2_py),
        .i_w     (s6_w),
        .o_pos_x (o_res.pos_x),
        .o_pos_y (o_res.pos_y)
    );

endmodule

[design/csp_front.sv]
module csp_front #(
    parameter int MAX_POINTS = csp_pkg::DEF_MAX_POINTS,
    parameter int PW         = $clog2(MAX_POINTS)
) (
    input  logic                            i_clk,
    input  logic [1:0]                      i_en,
    input  csp_pkg::t_cfg                   i_cfg,
    input  logic                            i_cmd,
    input  logic [csp_pkg::PIDX_W-1:0]      i_idx,
    input  logic signed [csp_pkg::CRD_W-1:0] i_x,
    input  logic signed [csp_pkg::CRD_W-1:0] i_y,
    input  logic [csp_pkg::TIME_W-1:0]      i_time,
    output logic                            o_load,
    output logic [csp_pkg::PIDX_W-1:0]      o_idx,
    output logic signed [csp_pkg::CRD_W-1:0] o_x,
    output logic signed [csp_pkg::CRD_W-1:0] o_y,
    output logic [csp_pkg::U_W-1:0]         o_u,
    output logic [3:0][PW-1:0]              o_addr
);
    import csp_pkg::*;

    localparam int NW = $clog2(MAX_POINTS + 1);

    t_cmd                    r0_cmd;
    logic [PIDX_W-1:0]       r0_idx;
    logic signed [CRD_W-1:0] r0_x;
    logic signed [CRD_W-1:0] r0_y;
    logic [TIME_W-1:0]       r0_time;

    t_cmd                    r1_cmd;
    logic [PIDX_W-1:0]       r1_idx;
    logic signed [CRD_W-1:0] r1_x;
    logic signed [CRD_W-1:0] r1_y;
    logic [U_W-1:0]          r1_u;
    logic [3:0][PW-1:0]      r1_addr;

    logic [NW-1:0]           n_eff;
    logic [NW-1:0]           n_m1;
    logic [FRAC_W+NW-1:0]    prod;
    logic [NW-1:0]           seg;
    logic [U_W-1:0]          n_u;
    logic signed [NW+1:0]    pos;
    logic [3:0][PW-1:0]      n_addr;

    always_comb begin
        if (int'(i_cfg.num_points) > MAX_POINTS) begin
            n_eff = NW'(MAX_POINTS);
        end else if (int'(i_cfg.num_points) < 2) begin
            n_eff = NW'(2);
        end else begin
            n_eff = NW'(i_cfg.num_points);
        end
        n_m1 = n_eff - NW'(1);
        prod = (FRAC_W+NW)'(r0_time[FRAC_W-1:0]) * (FRAC_W+NW)'(n_m1);
        if (r0_time[FRAC_W]) begin
            seg = n_m1;
            n_u = {1'b1, FRAC_W'(0)};
        end else begin
            seg = prod[FRAC_W+NW-1:FRAC_W];
            n_u = {1'b0, prod[FRAC_W-1:0]};
        end
        pos = '0;
        for (int k = 0; k < 4; k++) begin
            pos = $signed({2'b00, seg}) + (NW+2)'(k) - (NW+2)'(1);
            if (pos < 0) begin
                n_addr[k] = '0;
            end else if (pos >= $signed({2'b00, n_eff})) begin
                n_addr[k] = PW'(n_m1);
            end else begin
                n_addr[k] = PW'(pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_cmd  <= t_cmd'(i_cmd);
            r0_idx  <= i_idx;
            r0_x    <= i_x;
            r0_y    <= i_y;
            r0_time <= i_time;
        end
        if (i_en[1]) begin
            r1_cmd  <= r0_cmd;
            r1_idx  <= r0_idx;
            r1_x    <= r0_x;
            r1_y    <= r0_y;
            r1_u    <= n_u;
            r1_addr <= n_addr;
        end
    end

    assign o_load = (r1_cmd == CMD_LOAD);
    assign o_idx  = r1_idx;
    assign o_x    = r1_x;
    assign o_y    = r1_y;
    assign o_u    = r1_u;
    assign o_addr = r1_addr;

endmodule

[design/csp_store.sv]
module csp_store #(
    parameter int MAX_POINTS = csp_pkg::DEF_MAX_POINTS,
    parameter int PW         = $clog2(MAX_POINTS)
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic                             i_load,
    input  logic [csp_pkg::PIDX_W-1:0]       i_idx,
    input  logic signed [csp_pkg::CRD_W-1:0] i_x,
    input  logic signed [csp_pkg::CRD_W-1:0] i_y,
    input  logic [3:0][PW-1:0]               i_addr,
    output logic signed [csp_pkg::CRD_W-1:0] o_px [4],
    output logic signed [csp_pkg::CRD_W-1:0] o_py [4]
);
    import csp_pkg::*;

    // two copies, two read ports each
    logic [2*CRD_W-1:0] mem_a [MAX_POINTS];
    logic [2*CRD_W-1:0] mem_b [MAX_POINTS];
    logic [2*CRD_W-1:0] r_rd  [4];

    logic          wr_ok;
    logic [PW-1:0] wr_addr;

    assign wr_ok   = i_vld && i_load && (int'(i_idx) < MAX_POINTS);
    assign wr_addr = PW'(i_idx);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (wr_ok) begin
                mem_a[wr_addr] <= {i_x, i_y};
                mem_b[wr_addr] <= {i_x, i_y};
            end
            r_rd[0] <= mem_a[i_addr[0]];
            r_rd[1] <= mem_a[i_addr[1]];
            r_rd[2] <= mem_b[i_addr[2]];
            r_rd[3] <= mem_b[i_addr[3]];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_px[k] = r_rd[k][2*CRD_W-1:CRD_W];
            o_py[k] = r_rd[k][CRD_W-1:0];
        end
    end

endmodule

[design/csp_basis.sv]
module csp_basis (
    input  logic                            i_clk,
    input  logic [4:0]                      i_en,
    input  csp_pkg::t_cfg                   i_cfg,
    input  logic [csp_pkg::U_W-1:0]         i_u,
    output logic signed [csp_pkg::W_W-1:0]  o_w [4]
);
    import csp_pkg::*;

    localparam logic signed [Q_W-1:0]  HALF_Q = Q_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [Q_W-1:0]  ONE_Q  = Q_W'(1) <<< (3 * FRAC_W);
    localparam logic signed [SP_W-1:0] HALF_S = SP_W'(1) <<< FRAC_W;

    function automatic logic signed [Q_W-1:0] rnd_q(input logic signed [Q_W-1:0] v);
        return (v + HALF_Q) >>> FRAC_W;
    endfunction

    logic [2*U_W-1:0]      t2_full;
    logic [T2_W+U_W-1:0]   t3_full;

    logic [U_W-1:0]        r2_u;
    logic [T2_W-1:0]       r2_t2;
    logic [U_W-1:0]        r3_u;
    logic [T2_W-1:0]       r3_t2;
    logic [T3_W-1:0]       r3_t3;
    logic signed [S_W-1:0] r4_s;
    logic signed [R_W-1:0] r4_r [4];
    logic signed [G_W-1:0] r4_g2;
    logic signed [G_W-1:0] r4_g3;
    logic signed [SP_W-1:0] r5_p [4];
    logic signed [G_W-1:0] r5_g2;
    logic signed [G_W-1:0] r5_g3;
    logic signed [W_W-1:0] r6_w [4];

    logic signed [Q_W-1:0] t3s, t2q, tq, h2, h3;
    logic signed [Q_W-1:0] q  [4];
    logic signed [Q_W-1:0] rq [4];
    logic signed [Q_W-1:0] rh2, rh3;
    logic signed [R_W-1:0] n_r [4];
    logic signed [SP_W-1:0] sh [4];
    logic signed [W_W-1:0] n_w [4];

    assign t2_full = i_u * i_u;
    assign t3_full = r2_t2 * r2_u;

    // basis polynomials in Q.48, rounded to Q.32
    always_comb begin
        t3s  = $signed(Q_W'(r3_t3));
        t2q  = $signed(Q_W'(r3_t2)) <<< FRAC_W;
        tq   = $signed(Q_W'(r3_u)) <<< (2 * FRAC_W);
        q[0] = (t2q <<< 1) - t3s - tq;
        q[1] = t2q - t3s;
        q[2] = t3s - (t2q <<< 1) + tq;
        q[3] = t3s - t2q;
        h2   = (t3s <<< 1) - (t2q <<< 1) - t2q + ONE_Q;
        h3   = (t2q <<< 1) + t2q - (t3s <<< 1);
        for (int k = 0; k < 4; k++) begin
            rq[k]  = rnd_q(q[k]);
            n_r[k] = rq[k][R_W-1:0];
        end
        rh2 = rnd_q(h2);
        rh3 = rnd_q(h3);
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sh[k] = (r5_p[k] + HALF_S) >>> (FRAC_W + 1);
        end
        n_w[0] = W_W'(sh[0]);
        n_w[1] = W_W'(sh[1]) + W_W'(r5_g2);
        n_w[2] = W_W'(sh[2]) + W_W'(r5_g3);
        n_w[3] = W_W'(sh[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r2_u  <= i_u;
            r2_t2 <= t2_full[T2_W-1:0];
        end
        if (i_en[1]) begin
            r3_u  <= r2_u;
            r3_t2 <= r2_t2;
            r3_t3 <= t3_full[T3_W-1:0];
        end
        if (i_en[2]) begin
            r4_s  <= S_W'(32'sd65536) - S_W'(i_cfg.tension);
            r4_r  <= n_r;
            r4_g2 <= rh2[G_W-1:0];
            r4_g3 <= rh3[G_W-1:0];
        end
        if (i_en[3]) begin
            for (int k = 0; k < 4; k++) begin
                r5_p[k] <= r4_s * r4_r[k];
            end
            r5_g2 <= r4_g2;
            r5_g3 <= r4_g3;
        end
        if (i_en[4]) begin
            r6_w <= n_w;
        end
    end

    assign o_w = r6_w;

endmodule

[design/csp_blend.sv]
module csp_blend (
    input  logic                             i_clk,
    input  logic [6:0]                       i_en,
    input  csp_pkg::t_cfg                    i_cfg,
    input  logic signed [csp_pkg::CRD_W-1:0] i_px [4],
    input  logic signed [csp_pkg::CRD_W-1:0] i_py [4],
    input  logic signed [csp_pkg::W_W-1:0]   i_w [4],
    output logic signed [csp_pkg::CRD_W-1:0] o_pos_x,
    output logic signed [csp_pkg::CRD_W-1:0] o_pos_y
);
    import csp_pkg::*;

    localparam int DLY = 4;
    localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(1) <<< (RND_SH - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(COORD_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(COORD_MIN);

    logic signed [CRD_W-1:0] r_dx [DLY][4];
    logic signed [CRD_W-1:0] r_dy [DLY][4];
    logic signed [CP_W-1:0]  r7_px [4];
    logic signed [CP_W-1:0]  r7_py [4];
    logic signed [ACC_W-1:0] r8_ax;
    logic signed [ACC_W-1:0] r8_ay;
    logic signed [CRD_W-1:0] r9_x;
    logic signed [CRD_W-1:0] r9_y;

    logic signed [ACC_W-1:0] shx, shy;
    logic signed [SUM_W-1:0] sx, sy;
    logic signed [CRD_W-1:0] n_x, n_y;

    always_comb begin
        shx = (r8_ax + HALF_A) >>> RND_SH;
        shy = (r8_ay + HALF_A) >>> RND_SH;
        sx  = SUM_W'(shx);
        sy  = SUM_W'(shy);
        if (i_cfg.relative_mode) begin
            sx = sx + SUM_W'(i_cfg.start_x);
            sy = sy + SUM_W'(i_cfg.start_y);
        end
        if (sx > SAT_HI) begin
            n_x = SAT_HI[CRD_W-1:0];
        end else if (sx < SAT_LO) begin
            n_x = SAT_LO[CRD_W-1:0];
        end else begin
            n_x = sx[CRD_W-1:0];
        end
        if (sy > SAT_HI) begin
            n_y = SAT_HI[CRD_W-1:0];
        end else if (sy < SAT_LO) begin
            n_y = SAT_LO[CRD_W-1:0];
        end else begin
            n_y = sy[CRD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dx[0] <= i_px;
            r_dy[0] <= i_py;
        end
        for (int s = 1; s < DLY; s++) begin
            if (i_en[s]) begin
                r_dx[s] <= r_dx[s-1];
                r_dy[s] <= r_dy[s-1];
            end
        end
        if (i_en[DLY]) begin
            for (int k = 0; k < 4; k++) begin
                r7_px[k] <= r_dx[DLY-1][k] * i_w[k];
                r7_py[k] <= r_dy[DLY-1][k] * i_w[k];
            end
        end
        if (i_en[DLY+1]) begin
            r8_ax <= ACC_W'(r7_px[0]) + ACC_W'(r7_px[1])
                   + ACC_W'(r7_px[2]) + ACC_W'(r7_px[3]);
            r8_ay <= ACC_W'(r7_py[0]) + ACC_W'(r7_py[1])
                   + ACC_W'(r7_py[2]) + ACC_W'(r7_py[3]);
        end
        if (i_en[DLY+2]) begin
            r9_x <= n_x;
            r9_y <= n_y;
        end
    end

    assign o_pos_x = r9_x;
    assign o_pos_y = r9_y;

endmodule
